@@ src/row_range_match_counter_core_macros.svh @@
// Assertion macros shared by the checker of row_range_match_counter_core.
// Each macro expects clk_i and rst_ni in scope; no other dependencies.
`ifndef ROW_RANGE_MATCH_COUNTER_CORE_MACROS_SVH
`define ROW_RANGE_MATCH_COUNTER_CORE_MACROS_SVH

// Same-cycle implication.
`define RRMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RRMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/rrmc_pkg.sv @@
// Shared constants and types for the row range match counter.
// No dependencies.
package rrmc_pkg;

  localparam int MAX_VECTOR  = 256;
  localparam int MAX_COLUMNS = 256;

  localparam int VAL_W   = 32;
  localparam int ENTRY_W = 8;
  localparam int ROW_W   = 16;
  localparam int CFG_W   = 9;
  localparam int CNT_W   = $clog2(MAX_VECTOR + 1);
  localparam int COL_W   = $clog2(MAX_COLUMNS + 1);

  // configuration register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_LENGTH  = 1'b1;

  // item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ELEM = 1'b1;

  // query token walking down the cell chain
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic [CNT_W-1:0]        left;   // entries still to be counted
    logic [CNT_W-1:0]        count;
  } rrmc_tok_t;

endpackage

@@ src/rrmc_cell.sv @@
// One cell of the match chain: holds one vector entry, tests the passing token.
// Depends on rrmc_pkg.
module rrmc_cell import rrmc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  rrmc_tok_t               tok_i,
  output rrmc_tok_t               tok_o
);

  logic signed [VAL_W-1:0] entry_q;
  rrmc_tok_t               tok_d, tok_q;
  logic                    hit;

  always_comb begin
    hit         = tok_i.valid && (tok_i.left != '0) &&
                  (entry_q >= tok_i.lo) && (entry_q <= tok_i.hi);
    tok_d       = tok_i;
    tok_d.left  = (tok_i.left == '0) ? '0 : tok_i.left - CNT_W'(1);
    tok_d.count = tok_i.count + CNT_W'(hit);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      entry_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ src/rrmc_chain.sv @@
// Row of MAX_VECTOR match cells with the load-address decode.
// Depends on rrmc_pkg and rrmc_cell.
module rrmc_chain import rrmc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic [ENTRY_W-1:0]      index_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  rrmc_tok_t               head_i,
  output rrmc_tok_t               tail_o
);

  rrmc_tok_t tok_w [MAX_VECTOR+1];

  assign tok_w[0] = head_i;

  for (genvar g = 0; g < MAX_VECTOR; g++) begin : g_cell
    logic load_en;
    assign load_en = load_i && ({{(32-ENTRY_W){1'b0}}, index_i} == 32'(g));

    rrmc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (load_en),
      .value_i (value_i),
      .tok_i   (tok_w[g]),
      .tok_o   (tok_w[g+1])
    );
  end

  assign tail_o = tok_w[MAX_VECTOR];

endmodule

@@ src/row_range_match_counter_core.sv @@
// Top level of the row range match counter.
// Depends on rrmc_pkg and rrmc_chain (which uses rrmc_cell).
//
// Usage:
//  - Items come in on start_i, accepted at a rising edge with start_i high and
//    busy_o low. op_i = OP_LOAD writes value_i into vector entry entry_index_i;
//    op_i = OP_ELEM delivers the next matrix element of the current row.
//  - Loads and ordinary elements produce nothing and never raise busy_o.
//  - The element that completes a row (columns_in_use elements) launches a
//    query token into a chain of MAX_VECTOR cells, one cell per vector entry.
//    The token moves one cell per cycle, and each cell adds its entry to the
//    count if it lies in [row min, row max] and is below vector_length.
//  - The result (row_index_o, match_count_o) shows on valid_o for exactly one
//    cycle, once the token has passed the head register and every chain cell.
//    busy_o is high from that accept until the result cycle; the next item may
//    be accepted in the result cycle itself. The chain length sets this walk.
//  - No item is accepted while a row's walk is on; loads and elements do not block.
//  - The receiver cannot stall; results are never held.
//  - Config (cfg_we_i/cfg_idx_i/cfg_wdata_i) writes land at once; write only
//    while idle. Reset clears the row state, the row counter and the chain
//    tokens; vector entries stay undefined until loaded.
module row_range_match_counter_core import rrmc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // command channel
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    op_i,
  input  logic [ENTRY_W-1:0]      entry_index_i,
  input  logic signed [VAL_W-1:0] value_i,
  // result channel
  output logic                    valid_o,
  output logic [ROW_W-1:0]        row_index_o,
  output logic [CNT_W-1:0]        match_count_o,
  // config write port
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i
);

  logic [CFG_W-1:0]        cols_cfg_q, len_cfg_q;
  logic [COL_W-1:0]        eff_cols, col_q, col_d, col_inc;
  logic [CNT_W-1:0]        eff_len;
  logic signed [VAL_W-1:0] min_q, min_d, max_q, max_d;
  logic [ROW_W-1:0]        row_q;
  logic                    walk_q;
  logic                    accept, elem_acc, load_acc, row_end;
  rrmc_tok_t               head_q, tail;

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= CFG_W'(1);
      len_cfg_q  <= CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COLUMNS: cols_cfg_q <= cfg_wdata_i;
        REG_LENGTH:  len_cfg_q  <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  // zero columns acts as one; both counts clamp to the configured maxima
  always_comb begin
    if (cols_cfg_q == '0) begin
      eff_cols = COL_W'(1);
    end else if (32'(cols_cfg_q) > MAX_COLUMNS) begin
      eff_cols = COL_W'(MAX_COLUMNS);
    end else begin
      eff_cols = COL_W'(cols_cfg_q);
    end
    if (32'(len_cfg_q) > MAX_VECTOR) begin
      eff_len = CNT_W'(MAX_VECTOR);
    end else begin
      eff_len = CNT_W'(len_cfg_q);
    end
  end

  // ---- handshake ----
  // busy drops in the result cycle so the next item can overlap it
  assign busy_o   = walk_q && !tail.valid;
  assign accept   = start_i && !busy_o;
  assign elem_acc = accept && (op_i == OP_ELEM);
  assign load_acc = accept && (op_i == OP_LOAD);

  // ---- row tracking: running min/max from the row's first element ----
  always_comb begin
    col_inc = col_q + COL_W'(1);
    row_end = elem_acc && (col_inc >= eff_cols);
    min_d   = min_q;
    max_d   = max_q;
    col_d   = col_q;
    if (elem_acc) begin
      if (col_q == '0) begin
        min_d = value_i;
        max_d = value_i;
      end else begin
        if (value_i < min_q) min_d = value_i;
        if (value_i > max_q) max_d = value_i;
      end
      col_d = row_end ? '0 : col_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      max_q  <= '0;
      col_q  <= '0;
      row_q  <= '0;
      walk_q <= 1'b0;
      head_q <= '0;
    end else begin
      min_q        <= min_d;
      max_q        <= max_d;
      col_q        <= col_d;
      head_q.valid <= row_end;
      // token payload: bounds, entries to count, zero count
      if (row_end) begin
        head_q.lo    <= min_d;
        head_q.hi    <= max_d;
        head_q.left  <= eff_len;
        head_q.count <= '0;
      end
      if (tail.valid) begin
        row_q <= row_q + ROW_W'(1);
      end
      // a new row end in the result cycle re-arms the walk
      if (row_end) begin
        walk_q <= 1'b1;
      end else if (tail.valid) begin
        walk_q <= 1'b0;
      end
    end
  end

  // ---- match chain, also the vector store ----
  rrmc_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load_acc),
    .index_i (entry_index_i),
    .value_i (value_i),
    .head_i  (head_q),
    .tail_o  (tail)
  );

  // ---- result: straight from the last cell's register ----
  assign valid_o       = tail.valid;
  assign row_index_o   = row_q;
  assign match_count_o = tail.count;

endmodule

@@ src/rrmc_checker.sv @@
// Port-level checker for row_range_match_counter_core, bound to the top level.
// Depends on rrmc_pkg and row_range_match_counter_core_macros.svh.
`include "row_range_match_counter_core_macros.svh"

module rrmc_checker import rrmc_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_o,
  input logic                    op_i,
  input logic                    valid_o,
  input logic [ROW_W-1:0]        row_index_o
);

  // a result always frees the command channel
  `RRMC_ASSERT_IMP(a_res_not_busy, valid_o, !busy_o, "busy during result cycle")
  // one walk gives one result
  `RRMC_ASSERT_NXT(a_res_single, valid_o, !valid_o, "back-to-back results")
  // loads never start a walk
  `RRMC_ASSERT_NXT(a_load_idle, start_i && !busy_o && (op_i == OP_LOAD), !busy_o,
                   "load made the block busy")
  // row number advances by one after each result
  `RRMC_ASSERT_NXT(a_row_step, valid_o, row_index_o == $past(row_index_o) + 16'd1,
                   "row number did not advance")

endmodule

bind row_range_match_counter_core rrmc_checker u_rrmc_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for row_range_match_counter_core.
// Holds its own model of the per-row range count. Needs rrmc_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;
  import rrmc_pkg::*;

  // Generous cycle limit. Worst case: every item ends a row and waits out the full
  // walk, plus sender gaps and the settle pauses around register writes.
  localparam int unsigned RUN_LIMIT     = 1_500_000;
  // Loads and non-final elements leave nothing in flight, so this settle pause
  // is plenty before a register write.
  localparam int          SETTLE_CYCLES = 4;
  localparam int          GAP_PERCENT   = 32;
  localparam int          LOAD_PERCENT  = 20;
  localparam int          PHASE_ITEMS   = 55;
  localparam int          NUM_PHASES    = 7;

  typedef struct {
    logic [ROW_W-1:0] row_idx;
    logic [CNT_W-1:0] hits;
  } row_count_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic                    op_i;
  logic [ENTRY_W-1:0]      entry_index_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    valid_o;
  logic [ROW_W-1:0]        row_index_o;
  logic [CNT_W-1:0]        match_count_o;
  logic                    cfg_we_i;
  logic                    cfg_idx_i;
  logic [CFG_W-1:0]        cfg_wdata_i;

  // Mirror of the block state, updated at each accepted item and register write.
  logic signed [VAL_W-1:0] vec_mirror [MAX_VECTOR];
  logic signed [VAL_W-1:0] row_lo;
  logic signed [VAL_W-1:0] row_hi;
  int                      col_pos;
  logic [ROW_W-1:0]        row_num;
  logic [CFG_W-1:0]        cols_reg;
  logic [CFG_W-1:0]        len_reg;

  // Counts still owed by the block, oldest row first.
  row_count_t              pending_counts [$];
  row_count_t              oldest;
  int                      fail_count;
  int unsigned             cycle_count;
  bit                      allow_gaps;

  row_range_match_counter_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .value_i       (value_i),
    .valid_o       (valid_o),
    .row_index_o   (row_index_o),
    .match_count_o (match_count_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result checker. valid_o is one cycle wide and cannot be held off, so every
  // strobe is sampled at the edge that closes its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected result: expected none, got row %0d count %0d",
                 $time, row_index_o, match_count_o);
        fail_count++;
      end else begin
        oldest = pending_counts.pop_front();
        if (row_index_o !== oldest.row_idx) begin
          $display("%0t: row_index mismatch: expected %0d, got %0d",
                   $time, oldest.row_idx, row_index_o);
          fail_count++;
        end
        if (match_count_o !== oldest.hits) begin
          $display("%0t: match_count mismatch on row %0d: expected %0d, got %0d",
                   $time, oldest.row_idx, oldest.hits, match_count_o);
          fail_count++;
        end
      end
    end else if (rst_ni && valid_o !== 1'b0) begin
      $display("%0t: valid_o unknown: expected 0 or 1, got %b", $time, valid_o);
      fail_count++;
    end
  end

  // Row count model: tracks the running min/max and, at the row end, counts the
  // vector entries below the length setting that lie inside [min, max].
  task automatic predict_range_count(input logic op, input logic [ENTRY_W-1:0] idx,
                                     input logic signed [VAL_W-1:0] val);
    int eff_cols;
    int eff_len;
    int hits;
    if (op == OP_LOAD) begin
      // 8-bit index never exceeds the store, so every load lands
      vec_mirror[idx] = val;
    end else begin
      if (col_pos == 0) begin
        row_lo = val;
        row_hi = val;
      end else begin
        if (val < row_lo) row_lo = val;
        if (val > row_hi) row_hi = val;
      end
      col_pos++;
      // zero columns acts as one; oversize saturates
      eff_cols = (cols_reg == 0) ? 1 : int'(cols_reg);
      if (eff_cols > MAX_COLUMNS) eff_cols = MAX_COLUMNS;
      // >= rather than ==: the column count may shrink in the middle of a row
      if (col_pos >= eff_cols) begin
        eff_len = int'(len_reg);
        if (eff_len > MAX_VECTOR) eff_len = MAX_VECTOR;
        hits = 0;
        for (int k = 0; k < eff_len; k++) begin
          if (vec_mirror[k] >= row_lo && vec_mirror[k] <= row_hi) hits++;
        end
        pending_counts.push_back('{row_idx: row_num, hits: CNT_W'(hits)});
        row_num++;
        col_pos = 0;
      end
    end
  endtask

  // Sends one item. Returns once it is accepted and the block is not busy, with start_i
  // still high, so back-to-back items never drop start_i in between.
  task automatic send_item(input logic op, input logic [ENTRY_W-1:0] idx,
                           input logic signed [VAL_W-1:0] val);
    if (allow_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < GAP_PERCENT);
    end
    start_i       <= 1'b1;
    op_i          <= op;
    entry_index_i <= idx;
    value_i       <= val;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    predict_range_count(op, idx, val);
  endtask

  // Quiet point: nothing owed, not walking, and the last item has settled.
  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_counts.size() != 0 || busy_o !== 1'b0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == REG_COLUMNS) cols_reg = data;
    else len_reg = data;
    cfg_we_i <= 1'b0;
  endtask

  // Values weighted toward a narrow band so ranges overlap the vector often,
  // with the signed extremes and full-width noise mixed in.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return VAL_W'(int'($urandom_range(0, 40)) - 20);
    if (sel < 65) begin
      case ($urandom_range(0, 3))
        0: return {1'b1, {(VAL_W-1){1'b0}}};
        1: return {1'b0, {(VAL_W-1){1'b1}}};
        2: return '1;
        default: return '0;
      endcase
    end
    return $urandom();
  endfunction

  // Reset register values; entries 0 and 1 loaded before any row can end.
  task automatic test_power_on_rows();
    send_item(OP_LOAD, 8'd0, 32'sd0);
    send_item(OP_LOAD, 8'd1, 32'sd100);
    send_item(OP_ELEM, 8'd0, 32'sd0);
    send_item(OP_ELEM, 8'd0, {1'b1, {(VAL_W-1){1'b0}}});
    send_item(OP_ELEM, 8'd255, {1'b0, {(VAL_W-1){1'b1}}});
  endtask

  // Zero columns behaves as one; zero length always counts nothing.
  task automatic test_register_zero();
    write_reg(REG_COLUMNS, '0);
    write_reg(REG_LENGTH, '0);
    send_item(OP_ELEM, 8'd0, 32'sd0);
    send_item(OP_ELEM, 8'd0, 32'sd100);
  endtask

  // Min and max come from the row's own first element; full signed span;
  // a load in the middle of a row counts at that row's end.
  task automatic test_row_min_max();
    write_reg(REG_COLUMNS, 9'd3);
    write_reg(REG_LENGTH, 9'd2);
    send_item(OP_ELEM, 8'd0, -32'sd5);
    send_item(OP_ELEM, 8'd0, 32'sd200);
    send_item(OP_ELEM, 8'd0, 32'sd7);
    send_item(OP_ELEM, 8'd0, {1'b0, {(VAL_W-1){1'b1}}});
    send_item(OP_ELEM, 8'd0, {1'b1, {(VAL_W-1){1'b0}}});
    send_item(OP_ELEM, 8'd0, 32'sd50);
    send_item(OP_ELEM, 8'd0, 32'sd150);
    send_item(OP_LOAD, 8'd0, 32'sd155);
    send_item(OP_ELEM, 8'd0, 32'sd160);
    send_item(OP_ELEM, 8'd0, 32'sd155);
  endtask

  // Column count drops below the elements already seen: next element ends the row.
  task automatic test_column_shrink();
    write_reg(REG_COLUMNS, 9'd4);
    send_item(OP_ELEM, 8'd0, 32'sd1);
    send_item(OP_ELEM, 8'd0, 32'sd2);
    write_reg(REG_COLUMNS, 9'd2);
    send_item(OP_ELEM, 8'd0, 32'sd155);
  endtask

  // Load every entry so that any vector length is safe from here on.
  task automatic test_vector_fill();
    for (int k = 0; k < MAX_VECTOR; k++) begin
      send_item(OP_LOAD, ENTRY_W'(k), pick_value());
    end
  endtask

  // Widest row at oversize length, then oversize columns at full length cut short.
  task automatic test_wide_rows();
    write_reg(REG_COLUMNS, 9'd256);
    write_reg(REG_LENGTH, '1);
    for (int k = 0; k < MAX_COLUMNS; k++) send_item(OP_ELEM, 8'd0, pick_value());
    write_reg(REG_COLUMNS, '1);
    write_reg(REG_LENGTH, 9'd256);
    for (int k = 0; k < 40; k++) send_item(OP_ELEM, 8'd0, pick_value());
    write_reg(REG_COLUMNS, 9'd40);
    send_item(OP_ELEM, 8'd0, pick_value());
  endtask

  // Mixed loads and elements under several register settings. Mostly short
  // rows so that many results come back; one phase runs without sender gaps.
  task automatic test_random_traffic();
    int unsigned phase_cols [NUM_PHASES] = '{1, 2, 3, 5, 8, 0, 4};
    int unsigned phase_len  [NUM_PHASES] = '{256, 17, 1, 0, 200, 64, 511};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_COLUMNS, CFG_W'(phase_cols[p]));
      write_reg(REG_LENGTH, CFG_W'(phase_len[p]));
      allow_gaps = (p != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < LOAD_PERCENT)
          send_item(OP_LOAD, ENTRY_W'($urandom_range(0, MAX_VECTOR - 1)), pick_value());
        else
          send_item(OP_ELEM, ENTRY_W'($urandom()), pick_value());
      end
    end
    allow_gaps = 1'b1;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    op_i          <= OP_LOAD;
    entry_index_i <= '0;
    value_i       <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_COLUMNS;
    cfg_wdata_i   <= '0;
    fail_count    = 0;
    cycle_count   = 0;
    allow_gaps    = 1'b1;
    // model reset state
    row_lo   = '0;
    row_hi   = '0;
    col_pos  = 0;
    row_num  = '0;
    cols_reg = 9'd1;
    len_reg  = 9'd1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_on_rows();
    test_register_zero();
    test_row_min_max();
    test_column_shrink();
    test_vector_fill();
    test_wide_rows();
    test_random_traffic();

    // Drain, then watch one full walk longer for stray results.
    start_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (MAX_VECTOR + 8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ row_range_match_counter_core.f @@
+incdir+src
src/rrmc_pkg.sv
src/rrmc_cell.sv
src/rrmc_chain.sv
src/row_range_match_counter_core.sv
src/rrmc_checker.sv
sim/testbench.sv
